// File: design/assert_macros.svh
// Assertion macros used by design/trackball_pad_nibble_port.sv.
// No dependencies; take in by `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted.
`define TPN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define TPN_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: design/tpn_pkg.sv
// Types and constants of the trackball pad nibble port.
// No dependencies.
package tpn_pkg;

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [6:0] TimeoutTicks  = 7'd60;
  localparam logic [6:0] MaxSpeedReset = 7'd63;

  typedef struct packed {
    logic [1:0]         mode;
    logic               th_level;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic               button_one;
    logic               button_two;
  } in_item_t;

  typedef struct packed {
    logic [6:0] read_data;
  } out_item_t;

  // input register contents handed to the core
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } stage_t;

endpackage

// File: design/tpn_in_if.sv
// Input channel of the nibble port: valid, ready and one input beat.
// Depends on tpn_pkg.
interface tpn_in_if;
  logic             valid;
  logic             ready;
  tpn_pkg::in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// File: design/tpn_out_if.sv
// Output channel of the nibble port: valid, ready and one result beat.
// Depends on tpn_pkg.
interface tpn_out_if;
  logic               valid;
  logic               ready;
  tpn_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/trackball_pad_nibble_port.sv
// Result path: a read beat passes the input register, then the result
// register, before its result appears; ticks and TH writes give no result.
// Throughput: one beat per cycle while the result is not stalled; a stalled
// result holds a read in the input register and blocks all beats behind it.
// Reset (rst_ni, async, low): TH high, timeout and index zero, nibbles zero,
// max_speed 63, both registers empty.
`include "assert_macros.svh"

module trackball_pad_nibble_port (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_data_i,
  tpn_in_if.sink     in_i,
  tpn_out_if.source  out_o
);
  import tpn_pkg::*;

  stage_t s1;
  logic   advance;

  tpn_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .s1_o      (s1)
  );

  tpn_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .s1_i       (s1),
    .advance_o  (advance),
    .out_o      (out_o)
  );

  // a result only appears after a read beat left the input register
  `TPN_ASSERT(a_result_from_read, $rose(out_o.valid) |-> $past(advance && s1.item.mode == MODE_READ), "result without a read beat")
  // an empty input register always takes a beat
  `TPN_ASSERT(a_ready_when_empty, !s1.valid |-> in_i.ready, "input stalled while empty")
  // only a valid beat can advance
  `TPN_ASSERT(a_advance_valid, advance |-> s1.valid, "advance with empty input register")
  `TPN_ASSERT_RST(a_reset_empty, !rst_ni |-> !out_o.valid, "result valid during reset")

endmodule

// File: design/tpn_in_stage.sv
// Input register of the nibble port; holds one beat until the core takes it.
// Depends on tpn_pkg and tpn_in_if.
module tpn_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  tpn_in_if.sink        in_i,
  input  logic          advance_i,
  output tpn_pkg::stage_t s1_o
);
  import tpn_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q, item_d;
  logic     accept;

  assign in_i.ready = !valid_q || advance_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (accept) begin
      valid_d = 1'b1;
      item_d  = in_i.item;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign s1_o.valid = valid_q;
  assign s1_o.item  = item_q;

endmodule

// File: design/tpn_core.sv
// Port state (TH line, timeout, nibble index and store) and result register.
// Depends on tpn_pkg and tpn_out_if.
module tpn_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [6:0]      cfg_data_i,
  input  tpn_pkg::stage_t s1_i,
  output logic            advance_o,
  tpn_out_if.source       out_o
);
  import tpn_pkg::*;

  logic [6:0] speed_q;
  logic       th_q, th_d;
  logic [6:0] tmo_q, tmo_d;
  logic [1:0] idx_q, idx_d;
  logic [3:0] nib_q [4];
  logic [3:0] nib_d [4];
  logic       out_valid_q, out_valid_d;
  logic [6:0] out_data_q, out_data_d;
  logic [7:0] ax_byte, ay_byte;
  logic       is_read;

  // negate with 16-bit wrap, clamp to +/- limit, keep the low byte
  function automatic logic [7:0] clamp_axis(logic signed [15:0] raw, logic [6:0] lim);
    logic signed [15:0] neg;
    logic signed [15:0] hi;
    logic signed [15:0] lo;
    logic signed [15:0] v;
    neg = -raw;
    hi  = $signed({9'd0, lim});
    lo  = -hi;
    if (neg > hi) begin
      v = hi;
    end else if (neg < lo) begin
      v = lo;
    end else begin
      v = neg;
    end
    return v[7:0];
  endfunction

  assign ax_byte   = clamp_axis(s1_i.item.axis_x, speed_q);
  assign ay_byte   = clamp_axis(s1_i.item.axis_y, speed_q);
  assign is_read   = s1_i.item.mode == MODE_READ;
  // a read may only go ahead when the result register is free or draining
  assign advance_o = s1_i.valid && (!is_read || !out_valid_q || out_o.ready);

  always_comb begin
    th_d        = th_q;
    tmo_d       = tmo_q;
    idx_d       = idx_q;
    nib_d       = nib_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !out_o.ready;
    if (advance_o) begin
      case (s1_i.item.mode)
        MODE_TICK: begin
          if (!th_q && tmo_q != 7'd0) begin
            tmo_d = tmo_q - 7'd1;
            if (tmo_q == 7'd1) begin
              idx_d    = 2'd0;
              nib_d[0] = ax_byte[7:4];
              nib_d[1] = ax_byte[3:0];
              nib_d[2] = ay_byte[7:4];
              nib_d[3] = ay_byte[3:0];
            end
          end
        end
        MODE_WRITE: begin
          if (th_q && !s1_i.item.th_level) begin
            tmo_d = TimeoutTicks;
            idx_d = idx_q + 2'd1;
          end else if (!th_q && s1_i.item.th_level) begin
            idx_d = idx_q + 2'd1;
          end
          th_d = s1_i.item.th_level;
        end
        MODE_READ: begin
          out_valid_d = 1'b1;
          out_data_d  = {1'b1, !s1_i.item.button_two, !s1_i.item.button_one, nib_q[idx_q]};
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q     <= MaxSpeedReset;
      th_q        <= 1'b1;
      tmo_q       <= 7'd0;
      idx_q       <= 2'd0;
      nib_q       <= '{default: 4'd0};
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        speed_q <= cfg_data_i;
      end
      th_q        <= th_d;
      tmo_q       <= tmo_d;
      idx_q       <= idx_d;
      nib_q       <= nib_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.data.read_data = out_data_q;

endmodule
